### sv/ncdf_pkg.sv
// Package for the normal CDF core: fixed-point formats, Horner coefficient
// tables and the sideband struct that travels along the cell chain.
// No dependencies.
package ncdf_pkg;

  // Widths of the datapath.
  localparam int unsigned Z_W    = 24;  // signed Q8.16 score
  localparam int unsigned P_W    = 17;  // unsigned Q1.16 probability
  localparam int unsigned ACC_W  = 38;  // signed Q8.30 Horner accumulator
  localparam int unsigned T_W    = 32;  // signed Q2.30 Horner argument
  localparam int unsigned Y_W    = 30;  // unsigned Q0.30 half magnitude, inner range
  localparam int unsigned CELLS  = 14;  // Horner steps of the longer polynomial

  // Range limits on |z| in Q16.
  localparam logic [Z_W-1:0] LIMIT_Q16 = 24'd393216;  // |z| >= 6.0
  localparam logic [Z_W-1:0] TWO_Q16   = 24'd131072;  // |z| <  2.0

  // Q2.30 constants.
  localparam logic [T_W:0] TWO_Q30 = 33'd2147483648;
  localparam logic signed [39:0] ONE_Q30 = 40'sd1073741824;
  localparam logic [P_W-1:0] OUT_MAX = 17'd65536;

  // Decimal coefficients are integers times 1e-12, scaled to Q2.30 with rounding.
  localparam longint QS = 64'sd262144;
  localparam longint QR = 64'sd122070312;
  localparam longint QD = 64'sd244140625;

  // Inner polynomial in y*y, padded with leading zeros so both polynomials
  // take the same number of Horner steps.
  localparam logic signed [ACC_W-1:0] COEF_IN [CELLS+1] = '{
    38'sd0, 38'sd0, 38'sd0, 38'sd0, 38'sd0, 38'sd0,
    38'((64'sd124818987 * QS + QR) / QD),
    38'(-((64'sd1075204047 * QS + QR) / QD)),
    38'((64'sd5198775019 * QS + QR) / QD),
    38'(-((64'sd19198292004 * QS + QR) / QD)),
    38'((64'sd59054035642 * QS + QR) / QD),
    38'(-((64'sd151968751364 * QS + QR) / QD)),
    38'((64'sd319152932694 * QS + QR) / QD),
    38'(-((64'sd531923007300 * QS + QR) / QD)),
    38'((64'sd797884560593 * QS + QR) / QD)
  };

  // Outer polynomial in y - 2.
  localparam logic signed [ACC_W-1:0] COEF_OUT [CELLS+1] = '{
    38'(-((64'sd45255659 * QS + QR) / QD)),
    38'((64'sd152529290 * QS + QR) / QD),
    38'(-((64'sd19538132 * QS + QR) / QD)),
    38'(-((64'sd676904986 * QS + QR) / QD)),
    38'((64'sd1390604284 * QS + QR) / QD),
    38'(-((64'sd794620820 * QS + QR) / QD)),
    38'(-((64'sd2034254874 * QS + QR) / QD)),
    38'((64'sd6549791214 * QS + QR) / QD),
    38'(-((64'sd10557625006 * QS + QR) / QD)),
    38'((64'sd11630447319 * QS + QR) / QD),
    38'(-((64'sd9279453341 * QS + QR) / QD)),
    38'((64'sd5353579108 * QS + QR) / QD),
    38'(-((64'sd2141268741 * QS + QR) / QD)),
    38'((64'sd535310849 * QS + QR) / QD),
    38'((64'sd999936657524 * QS + QR) / QD)
  };

  // Sideband that rides with each transaction through the chain.
  typedef struct packed {
    logic                  pos;    // score is non-negative
    logic                  tail;   // |z| >= 6, result saturates
    logic                  inner;  // |z| < 2, inner polynomial
    logic signed [T_W-1:0] t;      // Horner argument
    logic [Y_W-1:0]        y;      // |z|/2 for the final inner multiply
  } ncdf_side_t;

endpackage

### sv/ncdf_front.sv
// Front end of the normal CDF core: input register, range split and the
// squaring stage that forms the Horner argument. Depends on ncdf_pkg.
module ncdf_front import ncdf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [Z_W-1:0]   z_i,
  output logic                    valid_o,
  output ncdf_side_t              side_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam logic [61:0] SQ_RND = 62'd1 << 29;

  logic                  v0_q;
  logic signed [Z_W-1:0] z_q;
  logic [Z_W-1:0]        mag;
  logic                  v1_q;
  logic                  pos_q, tail_q, inner_q;
  logic [T_W-1:0]        y_q;
  logic [61:0]           sq;
  logic [T_W:0]          shifted;
  ncdf_side_t            side_d, side_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q <= z_i;
    end
  end

  // Magnitude and range classification; y is |z|/2 in Q2.30.
  assign mag = z_q[Z_W-1] ? Z_W'(-z_q) : Z_W'(z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q   <= ~z_q[Z_W-1];
      tail_q  <= (mag >= LIMIT_Q16);
      inner_q <= (mag < TWO_Q16);
      y_q     <= {mag[18:0], 13'd0};
    end
  end

  // Square of y for the inner range, shifted y for the outer range.
  assign sq      = 62'(y_q[Y_W-1:0]) * 62'(y_q[Y_W-1:0]);
  assign shifted = {1'b0, y_q} - TWO_Q30;

  always_comb begin
    side_d.pos   = pos_q;
    side_d.tail  = tail_q;
    side_d.inner = inner_q;
    side_d.y     = y_q[Y_W-1:0];
    if (inner_q) begin
      side_d.t = T_W'((sq + SQ_RND) >> 30);
    end else begin
      side_d.t = T_W'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
    end
  end

  assign side_o = side_q;
  assign acc_o  = side_q.inner ? COEF_IN[0] : COEF_OUT[0];

endmodule

### sv/ncdf_cell.sv
// One Horner cell: acc * t rounded to Q2.30 plus this cell's coefficient,
// in two register stages (split partial products, then sum). Depends on ncdf_pkg.
module ncdf_cell import ncdf_pkg::*; #(
  parameter logic signed [ACC_W-1:0] C_IN  = '0,
  parameter logic signed [ACC_W-1:0] C_OUT = '0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  ncdf_side_t              side_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output logic                    valid_o,
  output ncdf_side_t              side_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam logic signed [71:0] RND = 72'sd1 <<< 29;

  logic                    va_q;
  ncdf_side_t              side_a_q;
  logic signed [50:0]      p_hi_d, p_hi_q;
  logic signed [51:0]      p_lo_d, p_lo_q;
  logic signed [71:0]      sum;
  logic signed [71:0]      rounded;
  logic signed [ACC_W-1:0] coef;
  logic signed [ACC_W-1:0] acc_d, acc_q;
  ncdf_side_t              side_b_q;

  // Partial products of the upper and lower halves of the accumulator.
  assign p_hi_d = $signed(acc_i[ACC_W-1:19]) * side_i.t;
  assign p_lo_d = $signed({1'b0, acc_i[18:0]}) * side_i.t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      va_q    <= valid_i;
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_a_q <= side_i;
      p_hi_q   <= p_hi_d;
      p_lo_q   <= p_lo_d;
    end
  end

  // Recombine, round half up to Q2.30 and add the coefficient.
  assign sum     = (72'(p_hi_q) <<< 19) + 72'(p_lo_q) + RND;
  assign rounded = sum >>> 30;
  assign coef    = side_a_q.inner ? C_IN : C_OUT;
  assign acc_d   = ACC_W'(rounded) + coef;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_b_q <= side_a_q;
      acc_q    <= acc_d;
    end
  end

  assign side_o = side_b_q;
  assign acc_o  = acc_q;

endmodule

### sv/ncdf_back.sv
// Back end of the normal CDF core: final multiply by y on the inner range,
// selection of x, (1 +/- x)/2 with saturation and the output register.
// Depends on ncdf_pkg.
module ncdf_back import ncdf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  ncdf_side_t              side_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output logic                    valid_o,
  output logic [P_W-1:0]          prob_o
);

  localparam logic signed [63:0] RND     = 64'sd1 <<< 29;
  localparam logic signed [39:0] OUT_RND = 40'sd16384;

  logic                    vf_q;
  ncdf_side_t              side_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [63:0]      prod_d, prod_q;
  logic signed [63:0]      prod_r;
  logic signed [39:0]      x;
  logic signed [39:0]      v;
  logic signed [39:0]      scaled;
  logic [P_W-1:0]          prob_d;
  logic [P_W-1:0]          prob_q;

  // Inner range: the accumulator stays below 2.0, so 33 bits carry it.
  assign prod_d = $signed(acc_i[32:0]) * $signed({1'b0, side_i.y});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vf_q    <= valid_i;
      valid_o <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      acc_q  <= acc_i;
      prod_q <= prod_d;
    end
  end

  // Select x, form 1 +/- x and scale to Q1.16 with saturation.
  assign prod_r = (prod_q + RND) >>> 30;

  always_comb begin
    if (side_q.tail) begin
      x = ONE_Q30;
    end else if (side_q.inner) begin
      x = 40'(prod_r) <<< 1;
    end else begin
      x = 40'(acc_q);
    end
    v      = side_q.pos ? (ONE_Q30 + x) : (ONE_Q30 - x);
    scaled = (v + OUT_RND) >>> 15;
    if (v < 0) begin
      prob_d = '0;
    end else if (scaled > 40'(OUT_MAX)) begin
      prob_d = OUT_MAX;
    end else begin
      prob_d = P_W'(scaled);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prob_q <= prob_d;
    end
  end

  assign prob_o = prob_q;

endmodule

### sv/normal_cdf_approximation_core.sv
// Top level of the normal CDF core: front end, a chain of Horner cells and
// the back end. Depends on ncdf_pkg, ncdf_front, ncdf_cell and ncdf_back.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+--------------------------
//   in      | input     | in_valid_i, in_stall_o | z_score_i, signed Q8.16
//   out     | output    | out_valid_o,out_stall_i| probability_o, Q1.16
//
// One transaction is accepted every cycle unless the pipeline holds. A result
// reaches the output through 33 register stages: three front-end stages, two
// stages in each of the 14 Horner cells and two back-end stages.
// The whole pipeline advances together; it holds only when the output register
// is full and stalled, and in_stall_o follows that.
// Reset clears the valid bits only; there is no stored state to initialize.
module normal_cdf_approximation_core import ncdf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [Z_W-1:0] z_score_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [P_W-1:0]        probability_o
);

  logic                    en;
  logic                    cell_valid [CELLS+1];
  ncdf_side_t              cell_side  [CELLS+1];
  logic signed [ACC_W-1:0] cell_acc   [CELLS+1];

  // Global advance: move when the output register is empty or being taken.
  assign en         = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = ~en;

  ncdf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .z_i     (z_score_i),
    .valid_o (cell_valid[0]),
    .side_o  (cell_side[0]),
    .acc_o   (cell_acc[0])
  );

  // Horner chain, one coefficient per cell.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    ncdf_cell #(
      .C_IN  (COEF_IN[i+1]),
      .C_OUT (COEF_OUT[i+1])
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_valid[i]),
      .side_i  (cell_side[i]),
      .acc_i   (cell_acc[i]),
      .valid_o (cell_valid[i+1]),
      .side_o  (cell_side[i+1]),
      .acc_o   (cell_acc[i+1])
    );
  end

  ncdf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cell_valid[CELLS]),
    .side_i  (cell_side[CELLS]),
    .acc_i   (cell_acc[CELLS]),
    .valid_o (out_valid_o),
    .prob_o  (probability_o)
  );

  // A stalled, full output register must hold the input side off.
  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input accepted while the output is stalled");

  // A delivered probability never exceeds 1.0.
  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (probability_o <= OUT_MAX))
    else $error("probability above 1.0");

  // A transaction leaving the front end enters the first cell on the next edge.
  a_chain_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && cell_valid[0]) |=> g_cell[0].u_cell.va_q)
    else $error("transaction lost at the head of the chain");

  // A stalled result stays on the output until it is taken.
  a_chain_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && out_valid_o) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule
